[rtl/gshp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ground strip heading picker: shared definitions
// Field widths, configuration register indexes and the queue status bundle.
// ----------------------------------------------------------------------------
package gshp_pkg;

	localparam int unsigned CNT_W   = 22;  // strip and total count width
	localparam int unsigned IDX_W   = 4;   // beam_index width
	localparam int unsigned ANG_W   = 8;   // angle_degrees width
	localparam int unsigned CFG_W   = 12;  // frame geometry register width
	localparam int unsigned RATIO_W = 16;  // threshold ratio width
	localparam int unsigned DATA_W  = 16;  // configuration write data width
	localparam int unsigned GEO_W   = 13;  // geometry compares, holds 4096

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic [GEO_W-1:0] MIN_WIDTH  = 13'd16;
	localparam logic [GEO_W-1:0] MIN_HEIGHT = 13'd2;

	localparam logic [8:0] ANGLE_BASE = 9'd90;

	typedef enum logic [1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1,
		CFG_SHARE_MIN    = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage : gshp_pkg
`default_nettype wire

[rtl/gshp_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ground strip heading picker: front end
// Tracks the raster position, counts ground pixels per strip in the bottom
// half of the frame and hands the strip counts to the queue at frame end.
// ----------------------------------------------------------------------------
module gshp_front
	import gshp_pkg::*;
#(
	parameter int unsigned N_STRIPS   = 10,
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    pixel_value,
	input  wire logic                          frame_start,
	input  wire logic [CFG_W-1:0]              frame_width,
	input  wire logic [CFG_W-1:0]              frame_height,
	input  wire q_stat_t                       q_stat,
	output logic                               push,
	output logic [N_STRIPS*CNT_W-1:0]          push_data
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned SW = $clog2(N_STRIPS + 1);
	localparam int unsigned MW = GEO_W + $clog2(N_STRIPS + 1);
	localparam logic [GEO_W-1:0] MAX_W_G = GEO_W'(MAX_WIDTH);
	localparam logic [GEO_W-1:0] MAX_H_G = GEO_W'(MAX_HEIGHT);
	localparam logic [MW-1:0] BEAMS_M = MW'(N_STRIPS);
	localparam logic [SW-1:0] BEAMS_S = SW'(N_STRIPS);

	logic [CW-1:0]    col_q, col_e;
	logic [RW-1:0]    row_q, row_e;
	logic [SW-1:0]    strip_q, strip_e;
	logic [CW-1:0]    cis_q, cis_e;
	logic [CNT_W-1:0] counts_q [N_STRIPS];
	logic [CNT_W-1:0] counts_n [N_STRIPS];

	logic [GEO_W-1:0] w, h, half, rows_used;
	logic             ground, in_band, row_end, frame_end, strip_wrap, accept;
	logic [MW-1:0]    wrap_lhs;

	// Geometry is saturated into its legal range before use.
	always_comb begin
		w = {1'b0, frame_width};
		if (w < MIN_WIDTH) begin
			w = MIN_WIDTH;
		end else if (w > MAX_W_G) begin
			w = MAX_W_G;
		end
		h = {1'b0, frame_height};
		if (h < MIN_HEIGHT) begin
			h = MIN_HEIGHT;
		end else if (h > MAX_H_G) begin
			h = MAX_H_G;
		end
		half      = h >> 1;
		rows_used = {h[GEO_W-1:1], 1'b0};
	end

	// A frame start pixel is pixel (0,0) of an empty frame.
	always_comb begin
		col_e   = frame_start ? '0 : col_q;
		row_e   = frame_start ? '0 : row_q;
		strip_e = frame_start ? '0 : strip_q;
		cis_e   = frame_start ? '0 : cis_q;
	end

	assign ground    = |pixel_value;
	assign in_band   = (GEO_W'(row_e) >= half) && (GEO_W'(row_e) < rows_used);
	assign row_end   = (GEO_W'(col_e) + GEO_W'(1)) >= w;
	assign frame_end = row_end && ((GEO_W'(row_e) + GEO_W'(1)) >= h);

	// The strip ends once column_in_strip + 1 reaches width / N_STRIPS,
	// which is the same as (column_in_strip + 2) * N_STRIPS > width.
	assign wrap_lhs   = (MW'(cis_e) + MW'(2)) * BEAMS_M;
	assign strip_wrap = wrap_lhs > MW'(w);

	always_comb begin
		for (int i = 0; i < N_STRIPS; i++) begin
			counts_n[i] = frame_start ? '0 : counts_q[i];
			if (ground && in_band && (strip_e == SW'(i)) && (counts_n[i] != CNT_MAX)) begin
				counts_n[i] = counts_n[i] + CNT_W'(1);
			end
			push_data[i*CNT_W +: CNT_W] = counts_n[i];
		end
	end

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && frame_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			strip_q <= '0;
			cis_q   <= '0;
			for (int i = 0; i < N_STRIPS; i++) begin
				counts_q[i] <= '0;
			end
		end else if (accept) begin
			if (row_end) begin
				col_q   <= '0;
				strip_q <= '0;
				cis_q   <= '0;
				row_q   <= frame_end ? '0 : row_e + RW'(1);
			end else begin
				col_q <= col_e + CW'(1);
				row_q <= row_e;
				if (strip_wrap) begin
					cis_q   <= '0;
					strip_q <= (strip_e < BEAMS_S) ? strip_e + SW'(1) : strip_e;
				end else begin
					cis_q   <= cis_e + CW'(1);
					strip_q <= strip_e;
				end
			end
			for (int i = 0; i < N_STRIPS; i++) begin
				counts_q[i] <= frame_end ? '0 : counts_n[i];
			end
		end
	end

endmodule : gshp_front
`default_nettype wire

[rtl/gshp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ground strip heading picker: frame queue
// Two-entry queue of per-frame strip count snapshots between the front and
// back ends.
// ----------------------------------------------------------------------------
module gshp_queue
	import gshp_pkg::*;
#(
	parameter int unsigned ENTRY_W = 220
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [ENTRY_W-1:0] push_data,
	input  wire logic               pop,
	output logic [ENTRY_W-1:0]      head,
	output q_stat_t                 q_stat
);

	logic [ENTRY_W-1:0] entry_q [2];
	logic               wr_ptr_q, rd_ptr_q;
	logic [1:0]         fill_q;

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = fill_q == 2'd2;
	assign q_stat.empty = fill_q == 2'd0;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule : gshp_queue
`default_nettype wire

[rtl/gshp_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ground strip heading picker: back end
// Sweeps one frame's strip counts for total and best, applies the share
// threshold and holds the decision in the output register.
// ----------------------------------------------------------------------------
module gshp_back
	import gshp_pkg::*;
#(
	parameter int unsigned N_STRIPS = 10
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [N_STRIPS*CNT_W-1:0]  head,
	input  wire q_stat_t                    q_stat,
	output logic                            pop,
	input  wire logic [RATIO_W-1:0]         share_min,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic                            decision_stop,
	output logic [IDX_W-1:0]                beam_index,
	output logic signed [ANG_W-1:0]         angle_degrees,
	output logic [CNT_W-1:0]                best_count,
	output logic [CNT_W-1:0]                total_count
);

	localparam int unsigned XW  = (N_STRIPS > 2) ? $clog2(N_STRIPS) : 1;
	localparam int unsigned TW  = CNT_W + $clog2(N_STRIPS + 1);
	localparam int unsigned PW  = TW + RATIO_W;
	localparam logic [XW-1:0] LAST_IDX = XW'(N_STRIPS - 1);
	localparam logic [7:0] ANG_STEP = 8'(180 / (N_STRIPS - 1));

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_ACC,
		ST_MUL,
		ST_DECIDE,
		ST_OUT
	} state_t;

	state_t           state_q;
	logic [XW-1:0]    idx_q;
	logic [TW-1:0]    total_q;
	logic [CNT_W-1:0] best_q;
	logic [IDX_W-1:0] bi_q;
	logic [PW-1:0]    prod_q;

	logic [CNT_W-1:0] cur;
	logic [PW-1:0]    best_scaled;
	logic             stop;
	logic [11:0]      ang_mul;

	assign cur         = head[idx_q*CNT_W +: CNT_W];
	assign pop         = (state_q == ST_ACC) && (idx_q == LAST_IDX);
	// best * 65536 against total * ratio, both exact.
	assign best_scaled = PW'({best_q, 16'd0});
	assign stop        = (total_q == '0) || (best_scaled < prod_q);
	assign ang_mul     = 12'(bi_q) * 12'(ANG_STEP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_LOAD;
			idx_q         <= '0;
			total_q       <= '0;
			best_q        <= '0;
			bi_q          <= '0;
			prod_q        <= '0;
			out_valid     <= 1'b0;
			decision_stop <= 1'b0;
			beam_index    <= '0;
			angle_degrees <= '0;
			best_count    <= '0;
			total_count   <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					idx_q   <= '0;
					total_q <= '0;
					best_q  <= '0;
					bi_q    <= '0;
					if (!q_stat.empty) begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					total_q <= total_q + TW'(cur);
					// Strictly greater keeps the lowest index on a tie.
					if (cur > best_q) begin
						best_q <= cur;
						bi_q   <= IDX_W'(idx_q);
					end
					if (idx_q == LAST_IDX) begin
						state_q <= ST_MUL;
					end else begin
						idx_q <= idx_q + XW'(1);
					end
				end
				ST_MUL: begin
					prod_q  <= PW'(total_q) * PW'(share_min);
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					decision_stop <= stop;
					beam_index    <= stop ? '0 : bi_q;
					angle_degrees <= stop ? '0 : ANG_W'(ang_mul[8:0] - ANGLE_BASE);
					best_count    <= best_q;
					total_count   <= (total_q > TW'(CNT_MAX)) ? CNT_MAX : CNT_W'(total_q);
					out_valid     <= 1'b1;
					state_q       <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule : gshp_back
`default_nettype wire

[rtl/ground_strip_heading_picker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ground strip heading picker
// Per-frame heading decision from a raster stream of ground-mask pixels.
// ----------------------------------------------------------------------------
// The block takes one mask pixel per clock for as long as the frame queue has
// room. A front end counts ground pixels per strip and, on the last pixel of
// a frame, moves the strip counts into a two-frame queue. A back end then
// sweeps the strips one per cycle through load, accumulate, multiply and
// decide states into the output register, where the decision is held while
// out_stall is high. The smallest frame is 32 pixels, so with the default
// N_STRIPS the pixel input only stalls when decisions are held back at the
// output long enough to fill the queue.
// Configuration writes are always taken and must only be made between frames.
// ----------------------------------------------------------------------------
module ground_strip_heading_picker_unit
	import gshp_pkg::*;
#(
	parameter int unsigned N_STRIPS   = 10,
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 2048
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          pixel_value,
	input  wire logic                frame_start,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     decision_stop,
	output logic [IDX_W-1:0]         beam_index,
	output logic signed [ANG_W-1:0]  angle_degrees,
	output logic [CNT_W-1:0]         best_count,
	output logic [CNT_W-1:0]         total_count,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [DATA_W-1:0]   cfg_data
);

	localparam int unsigned ENTRY_W = N_STRIPS * CNT_W;

	logic [CFG_W-1:0]   frame_width_q;
	logic [CFG_W-1:0]   frame_height_q;
	logic [RATIO_W-1:0] share_min_q;

	q_stat_t            q_stat;
	logic               push, pop;
	logic [ENTRY_W-1:0] push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= 12'd640;
			frame_height_q <= 12'd480;
			share_min_q    <= 16'd3277;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[CFG_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[CFG_W-1:0];
				CFG_SHARE_MIN:    share_min_q    <= cfg_data[RATIO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	gshp_front #(
		.N_STRIPS   (N_STRIPS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.pixel_value  (pixel_value),
		.frame_start  (frame_start),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.q_stat       (q_stat),
		.push         (push),
		.push_data    (push_data)
	);

	gshp_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	gshp_back #(
		.N_STRIPS (N_STRIPS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_stat          (q_stat),
		.pop             (pop),
		.share_min       (share_min_q),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.decision_stop   (decision_stop),
		.beam_index      (beam_index),
		.angle_degrees   (angle_degrees),
		.best_count      (best_count),
		.total_count     (total_count)
	);

endmodule : ground_strip_heading_picker_unit
`default_nettype wire
